// ===== rtl/ps2sc_pkg.sv =====
// Types, byte codes and the key-to-button table for the PS/2 scan-code decoder.
// No dependencies; every other file refers to this package by scoped names.

package ps2sc_pkg;

    // Width of one scan-code word and of the button mask.
    localparam int unsigned ByteW = 8;
    localparam int unsigned BtnW  = 12;
    localparam int unsigned SkipW = 3;

    // Prefix and special codes of scan-code set 2.
    localparam logic [ByteW-1:0] CodeBreak   = 8'hF0;
    localparam logic [ByteW-1:0] CodeExt     = 8'hE0;
    localparam logic [ByteW-1:0] CodePause   = 8'hE1;
    localparam logic [ByteW-1:0] CodePrtBrk  = 8'h7C;
    localparam logic [ByteW-1:0] CodePrtMake = 8'h12;

    // Number of raw words dropped after each multi-word sequence.
    localparam logic [SkipW-1:0] SkipPrtMake  = 3'd2;
    localparam logic [SkipW-1:0] SkipPrtBreak = 3'd3;
    localparam logic [SkipW-1:0] SkipPause    = 3'd7;

    // Button bits of the pad mask.
    localparam logic [BtnW-1:0] BtnB      = 12'h001;
    localparam logic [BtnW-1:0] BtnY      = 12'h002;
    localparam logic [BtnW-1:0] BtnSelect = 12'h004;
    localparam logic [BtnW-1:0] BtnStart  = 12'h008;
    localparam logic [BtnW-1:0] BtnUp     = 12'h010;
    localparam logic [BtnW-1:0] BtnDown   = 12'h020;
    localparam logic [BtnW-1:0] BtnLeft   = 12'h040;
    localparam logic [BtnW-1:0] BtnRight  = 12'h080;
    localparam logic [BtnW-1:0] BtnA      = 12'h100;
    localparam logic [BtnW-1:0] BtnX      = 12'h200;
    localparam logic [BtnW-1:0] BtnL      = 12'h400;
    localparam logic [BtnW-1:0] BtnR      = 12'h800;

    // Prefix tracking phase; the fourth encoding is unused and decodes as fresh.
    typedef enum logic [1:0] {
        PH_FRESH = 2'd0,
        PH_EXT   = 2'd1,
        PH_BREAK = 2'd2
    } t_phase;

    // Complete decoder state carried from one word to the next.
    typedef struct packed {
        t_phase           phase;
        logic             ext_seen;
        logic [SkipW-1:0] skip;
        logic [BtnW-1:0]  mask;
    } t_dec_state;

    // Button bit for a key code, or zero for a key that is not mapped.
    function automatic logic [BtnW-1:0] key_to_button(input logic [ByteW-1:0] code,
                                                      input logic             ext);
        logic [BtnW-1:0] btn;
        btn = '0;
        if (ext) begin
            case (code)
                8'h75:   btn = BtnUp;
                8'h6B:   btn = BtnLeft;
                8'h72:   btn = BtnDown;
                8'h74:   btn = BtnRight;
                default: btn = '0;
            endcase
        end else begin
            case (code)
                8'h1D:   btn = BtnUp;
                8'h1C:   btn = BtnLeft;
                8'h1B:   btn = BtnDown;
                8'h23:   btn = BtnRight;
                8'h43:   btn = BtnUp;
                8'h3B:   btn = BtnLeft;
                8'h42:   btn = BtnDown;
                8'h4B:   btn = BtnRight;
                8'h69:   btn = BtnY;
                8'h72:   btn = BtnB;
                8'h6B:   btn = BtnX;
                8'h73:   btn = BtnA;
                8'h7A:   btn = BtnL;
                8'h74:   btn = BtnR;
                8'h12:   btn = BtnSelect;
                8'h14:   btn = BtnStart;
                default: btn = '0;
            endcase
        end
        return btn;
    endfunction

endpackage

// ===== rtl/ps2sc_scan_if.sv =====
// Handshake channel that carries one raw scan-code word.
// Depends on ps2sc_pkg for the word width.

interface ps2sc_scan_if;
    logic                          valid;
    logic                          ready;
    logic [ps2sc_pkg::ByteW-1:0]   scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink   (input valid, input scan_byte, output ready);
endinterface

// ===== rtl/ps2sc_pad_if.sv =====
// Handshake channel that carries one gamepad button mask.
// Depends on ps2sc_pkg for the mask width.

interface ps2sc_pad_if;
    logic                         valid;
    logic                         ready;
    logic [ps2sc_pkg::BtnW-1:0]   buttons;

    modport source (output valid, output buttons, input ready);
    modport sink   (input valid, input buttons, output ready);
endinterface

// ===== rtl/ps2sc_decode.sv =====
// Next-state logic of the scan-code decoder: one word in, updated state out.
// Depends on ps2sc_pkg for the state struct, codes and key table.

module ps2sc_decode (
    input  logic [ps2sc_pkg::ByteW-1:0] i_byte,
    input  ps2sc_pkg::t_dec_state       i_state,
    output ps2sc_pkg::t_dec_state       o_state
);

    logic                         eff_ext;
    logic [ps2sc_pkg::BtnW-1:0]   btn;

    // The extended flag that applies to the code in this word.
    always_comb begin
        case (i_state.phase)
            ps2sc_pkg::PH_EXT:   eff_ext = 1'b1;
            ps2sc_pkg::PH_BREAK: eff_ext = i_state.ext_seen;
            default:             eff_ext = 1'b0;
        endcase
    end

    assign btn = ps2sc_pkg::key_to_button(i_byte, eff_ext);

    // Next state: drop words while skipping, else follow the prefix phase.
    always_comb begin
        o_state = i_state;
        if (i_state.skip != '0) begin
            o_state.skip = i_state.skip - 1'b1;
        end else begin
            case (i_state.phase)
                ps2sc_pkg::PH_EXT: begin
                    o_state.ext_seen = 1'b1;
                    if (i_byte == ps2sc_pkg::CodeBreak) begin
                        o_state.phase = ps2sc_pkg::PH_BREAK;
                    end else begin
                        o_state.phase = ps2sc_pkg::PH_FRESH;
                        if (i_byte == ps2sc_pkg::CodePrtMake) begin
                            o_state.skip = ps2sc_pkg::SkipPrtMake;
                        end else begin
                            o_state.mask = i_state.mask | btn;
                        end
                    end
                end
                ps2sc_pkg::PH_BREAK: begin
                    o_state.phase = ps2sc_pkg::PH_FRESH;
                    if (i_state.ext_seen && i_byte == ps2sc_pkg::CodePrtBrk) begin
                        o_state.skip = ps2sc_pkg::SkipPrtBreak;
                    end else begin
                        o_state.mask = i_state.mask & ~btn;
                    end
                end
                default: begin
                    // Fresh phase, and the unused encoding that behaves like it.
                    o_state.phase    = ps2sc_pkg::PH_FRESH;
                    o_state.ext_seen = 1'b0;
                    if (i_byte == ps2sc_pkg::CodeBreak) begin
                        o_state.phase = ps2sc_pkg::PH_BREAK;
                    end else if (i_byte == ps2sc_pkg::CodeExt) begin
                        o_state.phase = ps2sc_pkg::PH_EXT;
                    end else if (i_byte == ps2sc_pkg::CodePause) begin
                        o_state.skip = ps2sc_pkg::SkipPause;
                    end else begin
                        o_state.mask = i_state.mask | btn;
                    end
                end
            endcase
        end
    end

endmodule

// ===== rtl/ps2_scancode_to_pad_buttons.sv =====
// PS/2 set-2 scan-code decoder that keeps a twelve-bit gamepad button mask.
// Each word passes the input register, then its updated mask is held in the output register.
// Throughput: one word per cycle unless o_pad stalls; input register, decoder state and
// output register advance together whenever the output register is free or taken.
// Reset (synchronous, active low) releases all buttons and clears prefix tracking.
// Depends on ps2sc_pkg, ps2sc_scan_if, ps2sc_pad_if and ps2sc_decode.

module ps2_scancode_to_pad_buttons (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ps2sc_scan_if.sink    i_scan,
    ps2sc_pad_if.source   o_pad
);

    logic                          r_in_valid;
    logic [ps2sc_pkg::ByteW-1:0]   r_in_byte;
    ps2sc_pkg::t_dec_state         r_state;
    ps2sc_pkg::t_dec_state         n_state;
    logic                          r_out_valid;
    logic [ps2sc_pkg::BtnW-1:0]    r_out_buttons;
    logic                          advance;

    // The pipeline moves whenever the output register can take a new word.
    assign advance      = !r_out_valid || o_pad.ready;
    assign i_scan.ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_scan.ready) begin
            r_in_valid <= i_scan.valid;
        end
        if (i_scan.valid && i_scan.ready) begin
            r_in_byte <= i_scan.scan_byte;
        end
    end

    ps2sc_decode u_decode (
        .i_byte  (r_in_byte),
        .i_state (r_state),
        .o_state (n_state)
    );

    // Decoder state and result register update together for each word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase    <= ps2sc_pkg::PH_FRESH;
            r_state.ext_seen <= 1'b0;
            r_state.skip     <= '0;
            r_state.mask     <= '0;
            r_out_valid      <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
        if (advance && r_in_valid) begin
            r_out_buttons <= n_state.mask;
        end
    end

    assign o_pad.valid   = r_out_valid;
    assign o_pad.buttons = r_out_buttons;

endmodule
